// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps

package tsp_pkg;

	// Command codes placed in the result.
	localparam logic [1:0] CMD_SPEED = 2'h1;
	localparam logic [1:0] CMD_PWM   = 2'h3;

	// Request types. The spare code three is handled as the tiered mode.
	localparam logic [1:0] REQ_TIERED     = 2'd0;
	localparam logic [1:0] REQ_LINEAR     = 2'd1;
	localparam logic [1:0] REQ_NO_PUSH    = 2'd2;
	localparam logic [1:0] REQ_TIERED_ALT = 2'd3;

	// Deadbands, tier edges and tier multipliers.
	localparam logic [31:0] DEADBAND_TIER   = 32'd50;
	localparam logic [31:0] DEADBAND_LINEAR = 32'd5;
	localparam logic [31:0] TIER_FAR        = 32'd700;
	localparam logic [31:0] TIER_MID        = 32'd450;
	localparam logic [31:0] TIER_NEAR       = 32'd200;
	localparam logic [4:0]  MUL_FAR         = 5'd1;
	localparam logic [4:0]  MUL_MID         = 5'd18;
	localparam logic [4:0]  MUL_NEAR        = 5'd15;
	localparam logic [4:0]  MUL_CLOSE       = 5'd5;
	localparam logic signed [15:0] PUSH_MIN = 16'sd200;

	// Register reset values.
	localparam logic [11:0] IDLE_RESET    = 12'd500;
	localparam logic [15:0] RELEASE_RESET = 16'd3500;

	// Configuration register indexes.
	localparam logic [1:0] CFG_REF_MAX = 2'd0;
	localparam logic [1:0] CFG_REF_MIN = 2'd1;
	localparam logic [1:0] CFG_IDLE    = 2'd2;
	localparam logic [1:0] CFG_RELEASE = 2'd3;

	// Scaled reference times elapsed: 20 plus 32 bits.
	localparam int SCALE_W    = 20;
	localparam int PROD_W     = SCALE_W + 32;
	localparam int DIV_STEPS  = PROD_W;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] angle_error;
		logic [31:0]        elapsed;
		logic [31:0]        elapsed_max;
		logic               pwm_load;
		logic signed [15:0] pwm_value;
	} tsp_req_t;

	typedef struct packed {
		logic [1:0]         cmd_code;
		logic signed [15:0] cmd_data;
		logic signed [15:0] speed_now;
		logic               div_error;
	} tsp_cmd_t;

endpackage

// ===== rtl/tsp_chan_if.sv =====
`timescale 1ns / 1ps

interface tsp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tiered_speed_profile_with_release_timer_top.sv =====
`timescale 1ns / 1ps

// Tiered speed profile with idle release timer, run once per control period.
//
// Channels: "request" is a valid/ready sink carrying one control period's
// inputs; "command" is a valid/ready source carrying the resulting command
// word, the computed speed and the divide-error flag. A transaction happens on
// a rising edge with valid and ready both high. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data) and must only be used while idle.
//
// Sequence: a request outside the deadband with a nonzero divisor passes through
// a multiply step, 52 restoring-division steps on one shared subtractor, a
// saturate step and an update step before its command is loaded. Requests
// inside the deadband or with a zero divisor skip the multiply and divide and
// go straight to the saturate and update steps. The block handles one request
// at a time; ready comes back on the edge that loads the command.
//
// Reset clears pwm_q but not speed_q, and loads the idle counter with 500
// and the configuration with its defaults. If the receiver stalls, the result
// waits in the output register and the sequencer holds in its update step.
module tiered_speed_profile_with_release_timer_top (
	input  logic        clk,
	input  logic        arst_n,
	tsp_chan_if.sink    request,
	tsp_chan_if.source  command,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tsp_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SAT  = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [15:0] ref_max_q;
	logic signed [15:0] ref_min_q;
	logic [11:0]        idle_limit_q;
	logic [15:0]        release_limit_q;

	// Persistent period state.
	logic [15:0]        idle_count_q;
	logic signed [15:0] pwm_q;

	// Working registers of the current request.
	logic [SCALE_W-1:0] scale_q;
	logic               ref_neg_q;
	logic [31:0]        num_q;
	logic [31:0]        den_q;
	logic               zero_q;
	logic               err_q;
	logic               push_q;
	logic [PROD_W-1:0]  dq_q;
	logic [31:0]        rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [15:0] speed_q;

	// Output register.
	logic               out_valid_q;
	tsp_cmd_t           out_q;

	// Decode of the incoming request.
	tsp_req_t           req;
	logic [31:0]        e_mag;
	logic               linear;
	logic               deadband;
	logic signed [15:0] ref_sel;
	logic [4:0]         mul_sel;
	logic [15:0]        ref_mag;
	logic [SCALE_W-1:0] scale;
	logic               accept;

	assign req    = request.payload;
	assign accept = request.valid && request.ready;
	assign request.ready = (state_q == ST_IDLE);

	always_comb begin
		e_mag  = req.angle_error[31] ? 32'(-req.angle_error) : 32'(req.angle_error);
		linear = (req.req_type == REQ_LINEAR);
		deadband = linear ? (e_mag <= DEADBAND_LINEAR) : (e_mag <= DEADBAND_TIER);
		if (linear || e_mag > TIER_FAR) begin
			ref_sel = ref_max_q;
			mul_sel = MUL_FAR;
		end else if (e_mag > TIER_MID) begin
			ref_sel = ref_min_q;
			mul_sel = MUL_MID;
		end else if (e_mag > TIER_NEAR) begin
			ref_sel = ref_min_q;
			mul_sel = MUL_NEAR;
		end else begin
			ref_sel = ref_min_q;
			mul_sel = MUL_CLOSE;
		end
		ref_mag = ref_sel[15] ? 16'(-ref_sel) : 16'(ref_sel);
		scale   = SCALE_W'(ref_mag) * SCALE_W'(mul_sel);
	end

	// One restoring-division step: shift in the next dividend bit and try the divisor.
	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;

	always_comb begin
		trial = {rem_q, dq_q[PROD_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	// Saturation of the quotient and the minimum-magnitude push.
	logic signed [15:0] sat_v;
	logic signed [15:0] push_v;

	always_comb begin
		if (zero_q) begin
			sat_v = 16'sd0;
		end else if (ref_neg_q) begin
			sat_v = (dq_q > PROD_W'(32768)) ? 16'sh8000 : 16'(-dq_q[15:0]);
		end else begin
			sat_v = (dq_q > PROD_W'(32767)) ? 16'sh7fff : 16'(dq_q[15:0]);
		end
		push_v = sat_v;
		if (push_q) begin
			if (sat_v > 16'sd0 && sat_v < PUSH_MIN) begin
				push_v = PUSH_MIN;
			end else if (sat_v < 16'sd0 && sat_v > -PUSH_MIN) begin
				push_v = -PUSH_MIN;
			end
		end
	end

	// Idle counter, PWM register and command choice for the update step.
	logic [15:0]        idle_next;
	logic signed [15:0] pwm_next;
	tsp_cmd_t           cmd_next;
	logic               upd_go;

	always_comb begin
		if (speed_q == 16'sd0) begin
			idle_next = (idle_count_q != 16'hffff) ? 16'(idle_count_q + 16'd1) : idle_count_q;
			pwm_next  = pwm_q;
		end else begin
			idle_next = 16'd0;
			pwm_next  = 16'sd0;
		end
		if (idle_next > release_limit_q) begin
			idle_next = 16'(idle_limit_q);
			pwm_next  = 16'sd0;
		end
		if (idle_next < 16'(idle_limit_q)) begin
			cmd_next.cmd_code = CMD_SPEED;
			cmd_next.cmd_data = speed_q;
		end else begin
			cmd_next.cmd_code = CMD_PWM;
			cmd_next.cmd_data = pwm_next;
		end
		cmd_next.speed_now = speed_q;
		cmd_next.div_error = err_q;
		upd_go = (state_q == ST_UPD) && (!out_valid_q || command.ready);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_max_q       <= 16'sd0;
			ref_min_q       <= 16'sd0;
			idle_limit_q    <= IDLE_RESET;
			release_limit_q <= RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REF_MAX: ref_max_q       <= cfg_data;
				CFG_REF_MIN: ref_min_q       <= cfg_data;
				CFG_IDLE:    idle_limit_q    <= cfg_data[11:0];
				CFG_RELEASE: release_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idle_count_q <= IDLE_RESET;
			pwm_q        <= 16'sd0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			// A new command replaces one that leaves on this edge.
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (command.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.pwm_load) begin
							pwm_q <= req.pwm_value;
						end
						if (deadband || req.elapsed_max == 32'd0) begin
							state_q <= ST_SAT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						idle_count_q <= idle_next;
						pwm_q        <= pwm_next;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the current request.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					scale_q   <= scale;
					ref_neg_q <= ref_sel[15];
					num_q     <= req.elapsed;
					den_q     <= req.elapsed_max;
					zero_q    <= deadband || req.elapsed_max == 32'd0;
					err_q     <= !deadband && req.elapsed_max == 32'd0;
					push_q    <= req.req_type != REQ_NO_PUSH && !linear;
				end
			end
			ST_MUL: begin
				dq_q  <= PROD_W'(scale_q) * PROD_W'(num_q);
				rem_q <= 32'd0;
			end
			ST_DIV: begin
				rem_q <= fits ? diff[31:0] : trial[31:0];
				dq_q  <= {dq_q[PROD_W-2:0], fits};
			end
			ST_SAT: begin
				speed_q <= push_v;
			end
			ST_UPD: begin
				if (upd_go) begin
					out_q <= cmd_next;
				end
			end
			default: ;
		endcase
	end

	assign command.valid   = out_valid_q;
	assign command.payload = out_q;

	// A command is only loaded from the update step.
	a_load_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPD))
		else $error("command loaded outside the update step");

	// After a request transaction the block is not ready again in the cycle after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !request.ready)
		else $error("request accepted twice in a row");

	// A divide error always comes with zero speed.
	a_err_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && out_q.div_error |-> out_q.speed_now == 16'sd0)
		else $error("divide error with nonzero speed");

	// A speed command always carries the computed speed.
	a_speed_data: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && out_q.cmd_code == CMD_SPEED |-> out_q.cmd_data == out_q.speed_now)
		else $error("speed command data differs from computed speed");

	// The division step count stays inside the quotient width.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("division step count out of range");

endmodule
